// File: rtl/sdf_pkg.sv
// Package for the stream duplicate filter.
// Holds the request and result payload types, the controller command and status types and the default table depth.
// Depends on nothing.
`timescale 1ns / 1ps

package sdf_pkg;

    localparam int TABLE_DEPTH_DEF = 64;

    typedef struct packed {
        logic signed [31:0] value;
        logic               first_of_list;
        logic               last_of_list;
    } in_t;

    typedef struct packed {
        logic signed [31:0] out_value;
        logic               keep;
        logic               end_of_list;
        logic               table_overflow;
    } out_t;

    typedef struct packed {
        logic start;
        logic scan;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_blocked;
    } status_t;

endpackage

// File: rtl/sdf_ctrl.sv
// Controller state machine of the stream duplicate filter.
// Sequences accept, table scan and result hand-off; uses sdf_pkg types.
`timescale 1ns / 1ps

module sdf_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  sdf_pkg::status_t status,
    output sdf_pkg::cmd_t    cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                cmd.start = s_valid;
                if (s_valid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (status.scan_done && !status.out_blocked) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/sdf_datapath.sv
// Datapath of the stream duplicate filter: request register, seen-value memory,
// scan counter, comparator and result register. Uses sdf_pkg types.
`timescale 1ns / 1ps

module sdf_datapath #(
    parameter int TABLE_DEPTH = sdf_pkg::TABLE_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  sdf_pkg::in_t      s_data,
    input  logic              m_ready,
    output logic              m_valid,
    output sdf_pkg::out_t     m_data,
    input  sdf_pkg::cmd_t     cmd,
    output sdf_pkg::status_t  status
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    logic [30:0]   mem [TABLE_DEPTH];

    sdf_pkg::in_t  item_reg;
    logic          skip_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] idx_reg;
    logic [30:0]   rd_data_reg;
    logic          pend_reg;
    logic          hit_reg;
    logic          out_valid_reg;
    sdf_pkg::out_t out_reg;

    logic          negative;
    logic          single;
    logic [30:0]   mag;
    logic          match;
    logic          issue;
    logic          keep;
    logic          full;
    logic          store;

    assign negative = item_reg.value[31];
    assign single   = item_reg.first_of_list && item_reg.last_of_list;
    assign mag      = item_reg.value[30:0];
    assign match    = pend_reg && (rd_data_reg == mag);
    assign issue    = cmd.scan && !skip_reg && !hit_reg && !match && (idx_reg != count_reg);
    assign full     = (count_reg == DEPTH_C);
    assign keep     = single || (!negative && !hit_reg);
    assign store    = !single && !negative && !hit_reg && !full;

    assign status.scan_done   = skip_reg || hit_reg || (!pend_reg && (idx_reg == count_reg));
    assign status.out_blocked = out_valid_reg && !m_ready;

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            item_reg <= s_data;
            skip_reg <= (s_data.first_of_list && s_data.last_of_list) || s_data.value[31];
        end
        if (issue) begin
            rd_data_reg <= mem[idx_reg[AW-1:0]];
        end
        if (cmd.finish && store) begin
            mem[count_reg[AW-1:0]] <= mag;
        end
        if (cmd.finish) begin
            out_reg.out_value      <= item_reg.value;
            out_reg.keep           <= keep;
            out_reg.end_of_list    <= item_reg.last_of_list;
            out_reg.table_overflow <= !single && !negative && !hit_reg && full;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.start) begin
                if (s_data.first_of_list) begin
                    count_reg <= '0;
                end
                idx_reg  <= '0;
                pend_reg <= 1'b0;
                hit_reg  <= 1'b0;
            end else begin
                if (cmd.scan) begin
                    pend_reg <= issue;
                end
                if (issue) begin
                    idx_reg <= idx_reg + 1'b1;
                end
                if (match) begin
                    hit_reg <= 1'b1;
                end
                if (cmd.finish && store) begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (cmd.finish) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// File: rtl/stream_duplicate_filter_top.sv
// Stream duplicate filter, which marks the first occurrence of each non-negative value in a
// list and keeps a single-element list unchanged. The stored values of the current list are
// read from the seen-value memory one per cycle through its single read port and compared in
// turn. A result is ready without a scan for a negative value, a single-element list or an
// empty table. Otherwise the scan reads the N values stored for the current list, where N is
// at most TABLE_DEPTH, and stops early when the value matches a stored entry. The controller
// returns to idle as the result register loads, and only then accepts the next request.
// A result still waiting for m_ready holds that request in its scan until it is taken.
// Top level: instantiates sdf_ctrl and sdf_datapath; uses sdf_pkg.
`timescale 1ns / 1ps

module stream_duplicate_filter_top #(
    parameter int TABLE_DEPTH = sdf_pkg::TABLE_DEPTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  sdf_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output sdf_pkg::out_t m_data
);

    sdf_pkg::cmd_t    cmd;
    sdf_pkg::status_t status;

    sdf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    sdf_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data),
        .cmd     (cmd),
        .status  (status)
    );

endmodule

// File: sim/dedup_checker.sv
// Checker for the stream duplicate filter: watches both channels, predicts each result
// from the accepted requests, and compares the results in order of arrival.
// Depends on sdf_pkg for the request and result types.
`timescale 1ns / 1ps

module dedup_checker #(
    parameter int TABLE_DEPTH = sdf_pkg::TABLE_DEPTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  logic          s_ready,
    input  sdf_pkg::in_t  s_data,
    input  logic          m_valid,
    input  logic          m_ready,
    input  sdf_pkg::out_t m_data,
    output int            errors,
    output int            outstanding
);

    logic [30:0]   seen_tbl [TABLE_DEPTH];
    int            seen_cnt;
    sdf_pkg::out_t pending_results [$];

    function automatic sdf_pkg::out_t dedup_verdict(sdf_pkg::in_t req);
        sdf_pkg::out_t res;
        logic          hit;
        if (req.first_of_list) begin
            seen_cnt = 0;
        end
        res.out_value      = req.value;
        res.keep           = 1'b0;
        res.end_of_list    = req.last_of_list;
        res.table_overflow = 1'b0;
        if (req.first_of_list && req.last_of_list) begin
            res.keep = 1'b1;
        end else if (!req.value[31]) begin
            hit = 1'b0;
            for (int i = 0; i < seen_cnt; i++) begin
                if (seen_tbl[i] == req.value[30:0]) begin
                    hit = 1'b1;
                end
            end
            if (!hit) begin
                res.keep = 1'b1;
                if (seen_cnt < TABLE_DEPTH) begin
                    seen_tbl[seen_cnt] = req.value[30:0];
                    seen_cnt++;
                end else begin
                    res.table_overflow = 1'b1;
                end
            end
        end
        return res;
    endfunction

    task automatic compare_field(string fname, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t dedup_check: %s expected %h actual %h", $time, fname, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        sdf_pkg::out_t want;
        if (!aresetn) begin
            seen_cnt = 0;
            errors   = 0;
            pending_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t dedup_check: result expected none actual %h",
                             $time, m_data);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    compare_field("out_value", want.out_value, m_data.out_value);
                    compare_field("keep", want.keep, m_data.keep);
                    compare_field("end_of_list", want.end_of_list, m_data.end_of_list);
                    compare_field("table_overflow", want.table_overflow,
                                  m_data.table_overflow);
                end
            end
            if (s_valid && s_ready) begin
                pending_results.insert(pending_results.size(), dedup_verdict(s_data));
            end
        end
        outstanding <= pending_results.size();
    end

endmodule

// File: sim/testbench.sv
// Top of the stream duplicate filter testbench: clock, reset, request stimulus and the
// result receiver, with the verdict at the end.
// Depends on sdf_pkg, stream_duplicate_filter_top and dedup_checker.
`timescale 1ns / 1ps

module testbench;

    localparam int TABLE_DEPTH = sdf_pkg::TABLE_DEPTH_DEF;

    logic          aclk    = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    sdf_pkg::in_t  s_data  = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    sdf_pkg::out_t m_data;
    int            errors;
    int            outstanding;
    int            n_sent      = 0;
    bit            snd_idle_on = 1'b1;
    bit            rcv_idle_on = 1'b1;
    bit            hold_req    = 1'b0;

    always #5 aclk = ~aclk;

    stream_duplicate_filter_top #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    dedup_checker #(.TABLE_DEPTH(TABLE_DEPTH)) dedup_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic int pick_wait(bit on);
        if (!on || $urandom_range(0, 2) == 0) begin
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    function automatic logic [31:0] pick_value(logic [31:0] base, int pool);
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            return {1'b1, 31'($urandom)};
        end
        if (r < 14) begin
            return $urandom;
        end
        case (r)
            14: return 32'h0000_0000;
            15: return 32'h7FFF_FFFF;
            16: return 32'h8000_0000;
            17: return 32'hFFFF_FFFF;
            default: return base + $urandom_range(0, pool - 1);
        endcase
    endfunction

    task automatic send_item(logic [31:0] v, bit first, bit last);
        sdf_pkg::in_t req;
        int           gap;
        req.value         = v;
        req.first_of_list = first;
        req.last_of_list  = last;
        gap = pick_wait(snd_idle_on);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        n_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    task automatic send_list(int len);
        logic [31:0] base;
        int          pool;
        bit          first;
        bit          last;
        base = $urandom & 32'h7FFF_FF00;
        pool = $urandom_range(2, 24);
        for (int i = 0; i < len; i++) begin
            first = (i == 0) && ($urandom_range(0, 49) != 0);
            last  = (i == len - 1) && ($urandom_range(0, 29) != 0);
            send_item(pick_value(base, pool), first, last);
        end
    endtask

    // Fills the table past its depth, then repeats stored and overflowed values.
    task automatic fill_table();
        logic [31:0] base;
        int          len;
        int          k;
        base = $urandom & 32'h3FFF_FF00;
        len  = TABLE_DEPTH + $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
            send_item(base + 32'(i * 3), i == 0, 1'b0);
        end
        for (int j = 0; j < 6; j++) begin
            k = $urandom_range(0, len - 1);
            send_item(base + 32'(k * 3), 1'b0, j == 5);
        end
    endtask

    initial begin
        int stall;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                stall = pick_wait(rcv_idle_on);
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin
        int r;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_item(32'd7, 1'b0, 1'b0);
        send_item(32'd7, 1'b0, 1'b0);
        send_item(32'h8000_0000, 1'b1, 1'b1);
        send_item(32'h7FFF_FFFF, 1'b1, 1'b1);
        send_item(32'h0000_0000, 1'b1, 1'b0);
        send_item(32'h0000_0000, 1'b0, 1'b0);
        send_item(32'hFFFF_FFFF, 1'b0, 1'b0);
        send_item(32'h7FFF_FFFF, 1'b0, 1'b0);
        send_item(32'h7FFF_FFFF, 1'b0, 1'b0);
        send_item(32'h8000_0000, 1'b0, 1'b0);
        send_item(32'd5, 1'b0, 1'b1);
        send_item(32'd5, 1'b0, 1'b0);
        send_item(32'd9, 1'b0, 1'b1);
        send_item(32'hFFFF_FFFF, 1'b1, 1'b1);
        send_item(32'h5555_5555, 1'b1, 1'b0);
        send_item(32'h2AAA_AAAA, 1'b0, 1'b1);
        wait_drained();

        hold_req    = 1'b1;
        snd_idle_on = 1'b0;
        send_list(10);
        wait_drained();
        snd_idle_on = 1'b1;

        fill_table();

        while (n_sent < 740) begin
            r = $urandom_range(0, 99);
            snd_idle_on = (r % 5 != 0);
            rcv_idle_on = (r % 7 != 0);
            if (r < 2) begin
                fill_table();
            end else if (r < 8) begin
                wait_drained();
            end
            send_list($urandom_range(1, 16));
        end

        wait_drained();
        repeat (80) @(posedge aclk);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
